// ===== rtl/pab_pkg.sv =====
// ----------------------------------------------------------------------------
// pab_pkg
// Shared constants and types of the point and box query unit.
// ----------------------------------------------------------------------------
package pab_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DIST_BITS      = 64;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_HALF_X   = 3'd3,
        CFG_HALF_Y   = 3'd4,
        CFG_HALF_Z   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic dzero;
        logic face;
    } t_flags;

endpackage

// ===== rtl/pab_front.sv =====
// ----------------------------------------------------------------------------
// pab_front
// Front stages: clamping, plane distances, cross products, axis choice and
// the saturating squared distance.
// ----------------------------------------------------------------------------
module pab_front import pab_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_query  [3],
    input  logic signed [COORD_BITS-1:0] i_dir    [3],
    input  logic signed [COORD_BITS-1:0] i_center [3],
    input  logic        [COORD_BITS-2:0] i_half   [3],
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_q      [3],
    output logic signed [COORD_BITS-1:0] o_c      [3],
    output logic        [COORD_BITS-1:0] o_n      [3],
    output logic        [2:0]            o_sdir,
    output logic signed [COORD_BITS-1:0] o_near   [3],
    output logic        [DIST_BITS-1:0]  o_dist,
    output t_flags                       o_flags,
    output logic        [COORD_BITS:0]   o_hden,
    output logic        [COORD_BITS-1:0] o_hdiv,
    output logic        [COORD_BITS:0]   o_iden,
    output logic        [COORD_BITS-1:0] o_idiv
);

    localparam int C    = COORD_BITS;
    localparam int PW   = 2 * C + 1;
    localparam int SQW  = 2 * C + 2;
    localparam int SUMW = (SQW + 2 > DIST_BITS + 1) ? SQW + 2 : DIST_BITS + 1;

    logic [C-2:0] w_hu [3];

    logic                r_a_valid;
    logic signed [C-1:0] r_a_q  [3];
    logic signed [C-1:0] r_a_c  [3];
    logic        [C-2:0] r_a_hu [3];
    logic        [C-1:0] r_a_n  [3];
    logic        [2:0]   r_a_s;
    logic signed [C:0]   r_a_dq [3];
    logic signed [C:0]   r_a_lo [3];
    logic signed [C:0]   r_a_hi [3];
    logic                r_a_dz;

    logic signed [C-1:0] w_b_near [3];
    logic        [C:0]   w_b_d    [3];
    logic        [C:0]   w_b_adet [3];
    logic        [2:0]   w_b_face;

    logic                r_b_valid;
    logic signed [C-1:0] r_b_q    [3];
    logic signed [C-1:0] r_b_c    [3];
    logic        [C-2:0] r_b_hu   [3];
    logic        [C-1:0] r_b_n    [3];
    logic        [2:0]   r_b_s;
    logic signed [C-1:0] r_b_near [3];
    logic        [C:0]   r_b_d    [3];
    logic        [C:0]   r_b_adet [3];
    t_flags              r_b_flags;

    logic                r_c_valid;
    logic signed [C-1:0] r_c_q    [3];
    logic signed [C-1:0] r_c_c    [3];
    logic        [C-2:0] r_c_hu   [3];
    logic        [C-1:0] r_c_n    [3];
    logic        [2:0]   r_c_s;
    logic signed [C-1:0] r_c_near [3];
    logic        [C:0]   r_c_adet [3];
    t_flags              r_c_flags;
    logic        [SQW-1:0] r_c_sq [3];
    logic        [PW-1:0]  r_c_ph [3][3];
    logic        [PW-1:0]  r_c_pi [3][3];

    logic [1:0]      w_kh;
    logic [1:0]      w_ki;
    logic [SUMW-1:0] w_sum;

    logic                r_d_valid;
    logic signed [C-1:0] r_d_q    [3];
    logic signed [C-1:0] r_d_c    [3];
    logic        [C-1:0] r_d_n    [3];
    logic        [2:0]   r_d_s;
    logic signed [C-1:0] r_d_near [3];
    logic [DIST_BITS-1:0] r_d_dist;
    t_flags              r_d_flags;
    logic        [C:0]   r_d_hden;
    logic        [C-1:0] r_d_hdiv;
    logic        [C:0]   r_d_iden;
    logic        [C-1:0] r_d_idiv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_hu[i] = (i_half[i] == '0) ? (C-1)'(1) : i_half[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_q[i]  <= i_query[i];
                r_a_c[i]  <= i_center[i];
                r_a_hu[i] <= w_hu[i];
                r_a_n[i]  <= i_dir[i][C-1] ? (~i_dir[i] + C'(1)) : i_dir[i];
                r_a_s[i]  <= i_dir[i][C-1];
                r_a_dq[i] <= {i_query[i][C-1], i_query[i]} - {i_center[i][C-1], i_center[i]};
                r_a_lo[i] <= {i_center[i][C-1], i_center[i]} - {2'b00, w_hu[i]};
                r_a_hi[i] <= {i_center[i][C-1], i_center[i]} + {2'b00, w_hu[i]};
            end
            r_a_dz <= (i_dir[0] == '0) && (i_dir[1] == '0) && (i_dir[2] == '0);
        end
    end

    always_comb begin
        logic signed [C:0]   qe;
        logic        [C:0]   mdq;
        logic signed [C+1:0] det;
        for (int i = 0; i < 3; i++) begin
            qe  = {r_a_q[i][C-1], r_a_q[i]};
            mdq = r_a_dq[i][C] ? (~r_a_dq[i] + (C+1)'(1)) : r_a_dq[i];
            if (qe < r_a_lo[i]) begin
                w_b_near[i] = r_a_lo[i][C-1:0];
                w_b_d[i]    = r_a_lo[i] - qe;
            end else if (qe > r_a_hi[i]) begin
                w_b_near[i] = r_a_hi[i][C-1:0];
                w_b_d[i]    = qe - r_a_hi[i];
            end else begin
                w_b_near[i] = r_a_q[i];
                w_b_d[i]    = '0;
            end
            det         = {3'b000, r_a_hu[i]} - {1'b0, mdq};
            w_b_adet[i] = det[C+1] ? (C+1)'(0) - det[C:0] : det[C:0];
            w_b_face[i] = (det == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_b_q[i]    <= r_a_q[i];
                r_b_c[i]    <= r_a_c[i];
                r_b_hu[i]   <= r_a_hu[i];
                r_b_n[i]    <= r_a_n[i];
                r_b_near[i] <= w_b_near[i];
                r_b_d[i]    <= w_b_d[i];
                r_b_adet[i] <= w_b_adet[i];
            end
            r_b_s           <= r_a_s;
            r_b_flags.dzero <= r_a_dz;
            r_b_flags.face  <= |w_b_face;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_c_q[i]    <= r_b_q[i];
                r_c_c[i]    <= r_b_c[i];
                r_c_hu[i]   <= r_b_hu[i];
                r_c_n[i]    <= r_b_n[i];
                r_c_near[i] <= r_b_near[i];
                r_c_adet[i] <= r_b_adet[i];
                r_c_sq[i]   <= SQW'(r_b_d[i]) * SQW'(r_b_d[i]);
                for (int j = 0; j < 3; j++) begin
                    r_c_ph[i][j] <= PW'(r_b_n[i]) * PW'(r_b_hu[j]);
                    r_c_pi[i][j] <= PW'(r_b_n[i]) * PW'(r_b_adet[j]);
                end
            end
            r_c_s     <= r_b_s;
            r_c_flags <= r_b_flags;
        end
    end

    always_comb begin
        if ((r_c_ph[0][1] > r_c_ph[1][0]) && (r_c_ph[0][2] > r_c_ph[2][0])) begin
            w_kh = 2'd0;
        end else if (r_c_ph[1][2] > r_c_ph[2][1]) begin
            w_kh = 2'd1;
        end else begin
            w_kh = 2'd2;
        end
        if ((r_c_pi[0][1] > r_c_pi[1][0]) && (r_c_pi[0][2] > r_c_pi[2][0])) begin
            w_ki = 2'd0;
        end else if (r_c_pi[1][2] > r_c_pi[2][1]) begin
            w_ki = 2'd1;
        end else begin
            w_ki = 2'd2;
        end
        w_sum = SUMW'(r_c_sq[0]) + SUMW'(r_c_sq[1]) + SUMW'(r_c_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_d_q[i]    <= r_c_q[i];
                r_d_c[i]    <= r_c_c[i];
                r_d_n[i]    <= r_c_n[i];
                r_d_near[i] <= r_c_near[i];
            end
            r_d_s     <= r_c_s;
            r_d_flags <= r_c_flags;
            r_d_dist  <= (|w_sum[SUMW-1:DIST_BITS]) ? '1 : w_sum[DIST_BITS-1:0];
            r_d_hden  <= {2'b00, r_c_hu[w_kh]};
            r_d_hdiv  <= r_c_n[w_kh];
            r_d_iden  <= r_c_adet[w_ki];
            r_d_idiv  <= r_c_n[w_ki];
        end
    end

    assign o_valid = r_d_valid;
    assign o_q     = r_d_q;
    assign o_c     = r_d_c;
    assign o_n     = r_d_n;
    assign o_sdir  = r_d_s;
    assign o_near  = r_d_near;
    assign o_dist  = r_d_dist;
    assign o_flags = r_d_flags;
    assign o_hden  = r_d_hden;
    assign o_hdiv  = r_d_hdiv;
    assign o_iden  = r_d_iden;
    assign o_idiv  = r_d_idiv;

    a_zero_dir_products: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && r_c_flags.dzero |-> (r_c_ph[0][1] == '0) && (r_c_pi[1][0] == '0))
        else $error("Products of a zero direction are not zero.");

endmodule

// ===== rtl/pab_div3.sv =====
// ----------------------------------------------------------------------------
// pab_div3
// Three scaled quotients n_i * den / div sharing one divisor, one quotient
// bit per pipeline stage, with a side payload carried alongside.
// ----------------------------------------------------------------------------
module pab_div3 import pab_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int PAY_W      = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_n [3],
    input  logic [COORD_BITS:0]   i_den,
    input  logic [COORD_BITS-1:0] i_div,
    input  logic [PAY_W-1:0]      i_pay,
    output logic                  o_valid,
    output logic [COORD_BITS:0]   o_quo [3],
    output logic [PAY_W-1:0]      o_pay
);

    localparam int C  = COORD_BITS;
    localparam int QB = C + 1;
    localparam int PW = 2 * C + 1;

    logic              r_valid [0:QB];
    logic [C-1:0]      r_rem   [0:QB][3];
    logic [QB-1:0]     r_ql    [0:QB][3];
    logic [C-1:0]      r_div   [0:QB];
    logic [PAY_W-1:0]  r_pay   [0:QB];
    logic [PW-1:0]     w_prod  [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_prod[l] = PW'(i_n[l]) * PW'(i_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= w_prod[l][PW-1:QB];
                r_ql[0][l]  <= w_prod[l][QB-1:0];
            end
            r_div[0] <= i_div;
            r_pay[0] <= i_pay;
        end
    end

    for (genvar gs = 0; gs < QB; gs++) begin : g_stage
        logic [C:0] w_t    [3];
        logic [C:0] w_diff [3];
        logic       w_ge   [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                w_t[l]    = {r_rem[gs][l], r_ql[gs][l][QB-1]};
                w_diff[l] = w_t[l] - {1'b0, r_div[gs]};
                w_ge[l]   = (w_t[l] >= {1'b0, r_div[gs]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[gs+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[gs+1] <= r_valid[gs];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[gs+1][l] <= w_ge[l] ? w_diff[l][C-1:0] : w_t[l][C-1:0];
                    r_ql[gs+1][l]  <= {r_ql[gs][l][QB-2:0], w_ge[l]};
                end
                r_div[gs+1] <= r_div[gs];
                r_pay[gs+1] <= r_pay[gs];
            end
        end
    end

    assign o_valid = r_valid[QB];
    assign o_pay   = r_pay[QB];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            o_quo[l] = r_ql[QB][l];
        end
    end

endmodule

// ===== rtl/point_aabb_box_queries_unit.sv =====
// An accepted input beat passes through the front stages, the hit and inner quotient
// pipelines and the output register before it leaves as a result beat.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits at the output under stall.
// Reset clears all valid bits and sets the centre to zero and half sizes to 1.0.
// ----------------------------------------------------------------------------
// point_aabb_box_queries_unit
// Closest point, squared distance, surface hit and inner points against one
// configured axis-aligned box, fully pipelined.
// ----------------------------------------------------------------------------
module point_aabb_box_queries_unit import pab_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]      i_cfg_index,
    input  logic [COORD_BITS-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_query_x,
    input  logic signed [COORD_BITS-1:0] i_query_y,
    input  logic signed [COORD_BITS-1:0] i_query_z,
    input  logic signed [COORD_BITS-1:0] i_dir_x,
    input  logic signed [COORD_BITS-1:0] i_dir_y,
    input  logic signed [COORD_BITS-1:0] i_dir_z,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_near_x,
    output logic signed [COORD_BITS-1:0] o_near_y,
    output logic signed [COORD_BITS-1:0] o_near_z,
    output logic [DIST_BITS-1:0]         o_dist_sq,
    output logic signed [COORD_BITS-1:0] o_hit_x,
    output logic signed [COORD_BITS-1:0] o_hit_y,
    output logic signed [COORD_BITS-1:0] o_hit_z,
    output logic signed [COORD_BITS-1:0] o_inner_x,
    output logic signed [COORD_BITS-1:0] o_inner_y,
    output logic signed [COORD_BITS-1:0] o_inner_z,
    output logic                         o_hit_degenerate,
    output logic                         o_inner_degenerate
);

    localparam int C    = COORD_BITS;
    localparam int HP_W = 6 * C + 3 + DIST_BITS + $bits(t_flags);
    localparam int IP_W = 3 * C;
    localparam logic [C-2:0] HALF_RST = (C-1)'(1) << FRAC_BITS;

    logic signed [C-1:0] r_center [3];
    logic        [C-2:0] r_half   [3];
    logic                w_en;

    logic signed [C-1:0] w_query [3];
    logic signed [C-1:0] w_dir   [3];

    logic                w_f_valid;
    logic signed [C-1:0] w_f_q    [3];
    logic signed [C-1:0] w_f_c    [3];
    logic        [C-1:0] w_f_n    [3];
    logic        [2:0]   w_f_s;
    logic signed [C-1:0] w_f_near [3];
    logic [DIST_BITS-1:0] w_f_dist;
    t_flags              w_f_flags;
    logic        [C:0]   w_f_hden;
    logic        [C-1:0] w_f_hdiv;
    logic        [C:0]   w_f_iden;
    logic        [C-1:0] w_f_idiv;

    logic [HP_W-1:0] w_hpay_i;
    logic [HP_W-1:0] w_hpay_o;
    logic [IP_W-1:0] w_ipay_i;
    logic [IP_W-1:0] w_ipay_o;
    logic            w_hvalid;
    logic            w_ivalid;
    logic [C:0]      w_hquo [3];
    logic [C:0]      w_iquo [3];

    logic signed [C-1:0] w_oc    [3];
    logic signed [C-1:0] w_oq    [3];
    logic signed [C-1:0] w_onear [3];
    logic        [2:0]   w_os;
    logic [DIST_BITS-1:0] w_odist;
    t_flags              w_oflags;
    logic signed [C-1:0] w_hres  [3];
    logic signed [C-1:0] w_ires  [3];

    logic                r_out_valid;
    logic signed [C-1:0] r_near  [3];
    logic signed [C-1:0] r_hit   [3];
    logic signed [C-1:0] r_inner [3];
    logic [DIST_BITS-1:0] r_dist;
    logic                r_hdeg;
    logic                r_ideg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_center[i] <= '0;
                r_half[i]   <= HALF_RST;
            end
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CENTER_X: r_center[0] <= i_cfg_data;
                CFG_CENTER_Y: r_center[1] <= i_cfg_data;
                CFG_CENTER_Z: r_center[2] <= i_cfg_data;
                CFG_HALF_X:   r_half[0]   <= i_cfg_data[C-2:0];
                CFG_HALF_Y:   r_half[1]   <= i_cfg_data[C-2:0];
                CFG_HALF_Z:   r_half[2]   <= i_cfg_data[C-2:0];
                default: begin
                end
            endcase
        end
    end

    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    assign w_query[0] = i_query_x;
    assign w_query[1] = i_query_y;
    assign w_query[2] = i_query_z;
    assign w_dir[0]   = i_dir_x;
    assign w_dir[1]   = i_dir_y;
    assign w_dir[2]   = i_dir_z;

    pab_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_in_valid),
        .i_query  (w_query),
        .i_dir    (w_dir),
        .i_center (r_center),
        .i_half   (r_half),
        .o_valid  (w_f_valid),
        .o_q      (w_f_q),
        .o_c      (w_f_c),
        .o_n      (w_f_n),
        .o_sdir   (w_f_s),
        .o_near   (w_f_near),
        .o_dist   (w_f_dist),
        .o_flags  (w_f_flags),
        .o_hden   (w_f_hden),
        .o_hdiv   (w_f_hdiv),
        .o_iden   (w_f_iden),
        .o_idiv   (w_f_idiv)
    );

    assign w_hpay_i = {w_f_c[0], w_f_c[1], w_f_c[2], w_f_s,
                       w_f_near[0], w_f_near[1], w_f_near[2], w_f_dist, w_f_flags};
    assign w_ipay_i = {w_f_q[0], w_f_q[1], w_f_q[2]};

    pab_div3 #(
        .COORD_BITS (COORD_BITS),
        .PAY_W      (HP_W)
    ) u_hit_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_n     (w_f_n),
        .i_den   (w_f_hden),
        .i_div   (w_f_hdiv),
        .i_pay   (w_hpay_i),
        .o_valid (w_hvalid),
        .o_quo   (w_hquo),
        .o_pay   (w_hpay_o)
    );

    pab_div3 #(
        .COORD_BITS (COORD_BITS),
        .PAY_W      (IP_W)
    ) u_inner_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_n     (w_f_n),
        .i_den   (w_f_iden),
        .i_div   (w_f_idiv),
        .i_pay   (w_ipay_i),
        .o_valid (w_ivalid),
        .o_quo   (w_iquo),
        .o_pay   (w_ipay_o)
    );

    assign {w_oc[0], w_oc[1], w_oc[2], w_os,
            w_onear[0], w_onear[1], w_onear[2], w_odist, w_oflags} = w_hpay_o;
    assign {w_oq[0], w_oq[1], w_oq[2]} = w_ipay_o;

    always_comb begin
        logic signed [C+2:0] hsum;
        logic signed [C+2:0] isum;
        for (int i = 0; i < 3; i++) begin
            hsum = w_os[i] ? {{3{w_oc[i][C-1]}}, w_oc[i]} - {2'b00, w_hquo[i]}
                           : {{3{w_oc[i][C-1]}}, w_oc[i]} + {2'b00, w_hquo[i]};
            isum = w_os[i] ? {{3{w_oq[i][C-1]}}, w_oq[i]} - {2'b00, w_iquo[i]}
                           : {{3{w_oq[i][C-1]}}, w_oq[i]} + {2'b00, w_iquo[i]};
            if ((hsum[C+2:C-1] == '0) || (hsum[C+2:C-1] == '1)) begin
                w_hres[i] = hsum[C-1:0];
            end else begin
                w_hres[i] = hsum[C+2] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
            end
            if ((isum[C+2:C-1] == '0) || (isum[C+2:C-1] == '1)) begin
                w_ires[i] = isum[C-1:0];
            end else begin
                w_ires[i] = isum[C+2] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
            end
            if (w_oflags.dzero) begin
                w_hres[i] = w_oc[i];
            end
            if (w_oflags.dzero || w_oflags.face) begin
                w_ires[i] = w_oq[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_hvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_near[i]  <= w_onear[i];
                r_hit[i]   <= w_hres[i];
                r_inner[i] <= w_ires[i];
            end
            r_dist <= w_odist;
            r_hdeg <= w_oflags.dzero;
            r_ideg <= w_oflags.dzero || w_oflags.face;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_near_x           = r_near[0];
    assign o_near_y           = r_near[1];
    assign o_near_z           = r_near[2];
    assign o_dist_sq          = r_dist;
    assign o_hit_x            = r_hit[0];
    assign o_hit_y            = r_hit[1];
    assign o_hit_z            = r_hit[2];
    assign o_inner_x          = r_inner[0];
    assign o_inner_y          = r_inner[1];
    assign o_inner_z          = r_inner[2];
    assign o_hit_degenerate   = r_hdeg;
    assign o_inner_degenerate = r_ideg;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_hvalid == w_ivalid)
        else $error("Hit and inner quotient pipelines are out of step.");

    a_degenerate_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_hdeg |-> r_ideg)
        else $error("A zero direction beat is not flagged degenerate for inner.");

endmodule
